// ===== rtl/hhv_pkg.sv =====
// shared types, constants and saturating fixed-point helpers for the verlet step pipeline
package hhv_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int DT_BITS   = 17;
  localparam int SQRT_STEPS = WORD_BITS;
  localparam int DIV_STEPS  = FRAC_BITS + 1;
  localparam int Q_BITS     = FRAC_BITS + 1;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t MAX_W = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t MIN_W = {1'b1, {(WORD_BITS-1){1'b0}}};

  // configuration register indexes
  localparam logic [1:0] REG_LAMBDA   = 2'd0;
  localparam logic [1:0] REG_MU       = 2'd1;
  localparam logic [1:0] REG_RADIUS   = 2'd2;
  localparam logic [1:0] REG_STRENGTH = 2'd3;

  // per-item values carried along the pipeline
  typedef struct packed {
    word_t [2:0]        np;
    word_t [2:0]        vh;
    logic [DT_BITS-1:0] dt;
    word_t [2:0]        f;
  } ctx_t;

  function automatic word_t sat_add(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? MIN_W : MAX_W;
    return s[WORD_BITS-1:0];
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? MIN_W : MAX_W;
    return s[WORD_BITS-1:0];
  endfunction

  function automatic word_t sat_neg(word_t a);
    if (a == MIN_W) return MAX_W;
    return -a;
  endfunction

  // product of magnitudes, truncated, sign applied, saturated
  function automatic word_t fx_mul(word_t a, word_t b);
    logic                          neg;
    logic [WORD_BITS-1:0]          ma;
    logic [WORD_BITS-1:0]          mb;
    logic [2*WORD_BITS-1:0]        pr;
    logic [2*WORD_BITS-FRAC_BITS-1:0] r;
    logic [2*WORD_BITS-FRAC_BITS-1:0] lim;
    neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
    ma  = a[WORD_BITS-1] ? -a : a;
    mb  = b[WORD_BITS-1] ? -b : b;
    pr  = ma * mb;
    r   = pr[2*WORD_BITS-1:FRAC_BITS];
    lim = neg ? {{(WORD_BITS-FRAC_BITS){1'b0}}, 1'b1, {(WORD_BITS-1){1'b0}}}
              : {{(WORD_BITS-FRAC_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    if (r > lim) r = lim;
    return neg ? -r[WORD_BITS-1:0] : r[WORD_BITS-1:0];
  endfunction

  // multiply by one half, truncating toward zero
  function automatic word_t fx_half(word_t a);
    logic [WORD_BITS-1:0] m;
    m = a[WORD_BITS-1] ? -a : a;
    m = m >> 1;
    return a[WORD_BITS-1] ? -m : m;
  endfunction

  function automatic logic [WORD_BITS-1:0] mag(word_t a);
    return a[WORD_BITS-1] ? -a : a;
  endfunction

endpackage

// ===== rtl/henon_heiles_verlet_step.sv =====
// velocity verlet step of one particle in a henon-heiles potential with containment
//
// Fully pipelined: one particle per clock while not stalled (8 stages of
// half-step velocity, position and force products, 32 stages of a bit-per-stage
// square root for the distance, 17 stages of a bit-per-stage divider for the
// direction, 4 stages of containment, new acceleration and final velocity).
// The whole pipeline holds while the output beat waits on out_ready;
// in_ready is high whenever the output register is empty or being taken.
// Configuration writes are meant for when the pipeline is empty.
module henon_heiles_verlet_step (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hhv_pkg::word_t        pos_x,
  input  hhv_pkg::word_t        pos_y,
  input  hhv_pkg::word_t        pos_z,
  input  hhv_pkg::word_t        vel_x,
  input  hhv_pkg::word_t        vel_y,
  input  hhv_pkg::word_t        vel_z,
  input  hhv_pkg::word_t        acc_x,
  input  hhv_pkg::word_t        acc_y,
  input  hhv_pkg::word_t        acc_z,
  input  logic [16:0]           time_step,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hhv_pkg::word_t        new_pos_x,
  output hhv_pkg::word_t        new_pos_y,
  output hhv_pkg::word_t        new_pos_z,
  output hhv_pkg::word_t        new_vel_x,
  output hhv_pkg::word_t        new_vel_y,
  output hhv_pkg::word_t        new_vel_z,
  output hhv_pkg::word_t        new_acc_x,
  output hhv_pkg::word_t        new_acc_y,
  output hhv_pkg::word_t        new_acc_z
);

  localparam int W  = hhv_pkg::WORD_BITS;
  localparam int NS = hhv_pkg::SQRT_STEPS;
  localparam int ND = hhv_pkg::DIV_STEPS;
  localparam int QB = hhv_pkg::Q_BITS;
  localparam int DB = hhv_pkg::DT_BITS;

  // configuration registers
  hhv_pkg::word_t  lambda_gain;
  hhv_pkg::word_t  mu_gain;
  logic [W-2:0]    boundary_radius;
  logic [W-2:0]    containment_strength;

  always_ff @(posedge clk) begin
    if (rst) begin
      lambda_gain          <= W'(1) << hhv_pkg::FRAC_BITS;
      mu_gain              <= W'(1) << hhv_pkg::FRAC_BITS;
      boundary_radius      <= (W-1)'(1) << hhv_pkg::FRAC_BITS;
      containment_strength <= (W-1)'(1) << hhv_pkg::FRAC_BITS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        hhv_pkg::REG_LAMBDA:   lambda_gain          <= cfg_data;
        hhv_pkg::REG_MU:       mu_gain              <= cfg_data;
        hhv_pkg::REG_RADIUS:   boundary_radius      <= cfg_data[W-2:0];
        hhv_pkg::REG_STRENGTH: containment_strength <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves when the output register can take a beat
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  hhv_pkg::word_t in_p [3];
  hhv_pkg::word_t in_v [3];
  hhv_pkg::word_t in_a [3];
  assign in_p = '{pos_x, pos_y, pos_z};
  assign in_v = '{vel_x, vel_y, vel_z};
  assign in_a = '{acc_x, acc_y, acc_z};

  // front stage registers
  logic a_vld, b_vld, c_vld, d_vld, e_vld, f_vld, g_vld, h_vld;
  hhv_pkg::word_t a_p [3], a_v [3], a_m [3];
  hhv_pkg::word_t b_p [3], b_vh [3];
  hhv_pkg::word_t c_p [3], c_vh [3], c_t [3];
  hhv_pkg::word_t d_np [3], d_vh [3];
  logic [DB-1:0]  a_dt, b_dt, c_dt, d_dt;
  hhv_pkg::ctx_t  e_ctx, f_ctx, g_ctx, h_ctx;
  hhv_pkg::ctx_t  g_ctx_next, h_ctx_next;
  hhv_pkg::word_t e_xx, e_yy, e_zz, e_xy, e_yz;
  logic [2*W-1:0] e_sq [3];
  hhv_pkg::word_t f_lxy, f_myz, f_dxy, f_dyz;
  logic [2*W-1:0] f_sum, g_sum, h_sum;
  hhv_pkg::word_t g_lxx, g_mzz, g_myz;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0; b_vld <= 1'b0; c_vld <= 1'b0; d_vld <= 1'b0;
      e_vld <= 1'b0; f_vld <= 1'b0; g_vld <= 1'b0; h_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= in_valid; b_vld <= a_vld; c_vld <= b_vld; d_vld <= c_vld;
      e_vld <= d_vld;    f_vld <= e_vld; g_vld <= f_vld; h_vld <= g_vld;
    end
  end

  // force components merged into the carried context
  always_comb begin
    g_ctx_next      = f_ctx;
    g_ctx_next.f[0] = hhv_pkg::sat_sub(hhv_pkg::sat_neg(f_ctx.np[0]),
                                       hhv_pkg::sat_add(f_lxy, f_lxy));
    h_ctx_next      = g_ctx;
    h_ctx_next.f[1] = hhv_pkg::sat_sub(
                        hhv_pkg::sat_sub(hhv_pkg::sat_neg(g_ctx.np[1]), g_lxx),
                        hhv_pkg::sat_add(g_myz, g_myz));
    h_ctx_next.f[2] = hhv_pkg::sat_sub(hhv_pkg::sat_neg(g_ctx.np[2]), g_mzz);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // acceleration times step
      for (int i = 0; i < 3; i++) begin
        a_p[i] <= in_p[i];
        a_v[i] <= in_v[i];
        a_m[i] <= hhv_pkg::fx_mul(in_a[i], W'(time_step));
      end
      a_dt <= time_step;
      // half-step velocity
      for (int i = 0; i < 3; i++) begin
        b_p[i]  <= a_p[i];
        b_vh[i] <= hhv_pkg::sat_add(a_v[i], hhv_pkg::fx_half(a_m[i]));
      end
      b_dt <= a_dt;
      // velocity times step
      for (int i = 0; i < 3; i++) begin
        c_p[i]  <= b_p[i];
        c_vh[i] <= b_vh[i];
        c_t[i]  <= hhv_pkg::fx_mul(b_vh[i], W'(b_dt));
      end
      c_dt <= b_dt;
      // new position
      for (int i = 0; i < 3; i++) begin
        d_np[i] <= hhv_pkg::sat_add(c_p[i], c_t[i]);
        d_vh[i] <= c_vh[i];
      end
      d_dt <= c_dt;
      // position products and exact squares for the distance
      for (int i = 0; i < 3; i++) begin
        e_ctx.np[i] <= d_np[i];
        e_ctx.vh[i] <= d_vh[i];
        e_ctx.f[i]  <= '0;
        e_sq[i]     <= hhv_pkg::mag(d_np[i]) * hhv_pkg::mag(d_np[i]);
      end
      e_ctx.dt <= d_dt;
      e_xx <= hhv_pkg::fx_mul(d_np[0], d_np[0]);
      e_yy <= hhv_pkg::fx_mul(d_np[1], d_np[1]);
      e_zz <= hhv_pkg::fx_mul(d_np[2], d_np[2]);
      e_xy <= hhv_pkg::fx_mul(d_np[0], d_np[1]);
      e_yz <= hhv_pkg::fx_mul(d_np[1], d_np[2]);
      // coupling products and squared radius
      f_ctx <= e_ctx;
      f_lxy <= hhv_pkg::fx_mul(lambda_gain, e_xy);
      f_myz <= hhv_pkg::fx_mul(mu_gain, e_yz);
      f_dxy <= hhv_pkg::sat_sub(e_xx, e_yy);
      f_dyz <= hhv_pkg::sat_sub(e_yy, e_zz);
      f_sum <= e_sq[0] + e_sq[1] + e_sq[2];
      // x force and second coupling products
      g_ctx <= g_ctx_next;
      g_lxx <= hhv_pkg::fx_mul(lambda_gain, f_dxy);
      g_mzz <= hhv_pkg::fx_mul(mu_gain, f_dyz);
      g_myz <= f_myz;
      g_sum <= f_sum;
      // y and z force
      h_ctx <= h_ctx_next;
      h_sum <= g_sum;
    end
  end

  // square root, one result bit per stage
  logic           sq_vld  [NS];
  logic [2*W-1:0] sq_rad  [NS];
  logic [W+3:0]   sq_rem  [NS];
  logic [W-1:0]   sq_root [NS];
  hhv_pkg::ctx_t  sq_ctx  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic           vld_i;
    logic [2*W-1:0] rad_i;
    logic [W+3:0]   rem_i;
    logic [W-1:0]   root_i;
    hhv_pkg::ctx_t  ctx_i;
    logic [W+3:0]   rem2;
    logic [W+3:0]   trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign vld_i  = h_vld;
      assign rad_i  = h_sum;
      assign rem_i  = '0;
      assign root_i = '0;
      assign ctx_i  = h_ctx;
    end else begin : g_next
      assign vld_i  = sq_vld[k-1];
      assign rad_i  = sq_rad[k-1];
      assign rem_i  = sq_rem[k-1];
      assign root_i = sq_root[k-1];
      assign ctx_i  = sq_ctx[k-1];
    end

    assign rem2  = {rem_i[W+1:0], rad_i[2*W-1:2*W-2]};
    assign trial = {2'b00, root_i, 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k] <= 1'b0;
      end else if (adv) begin
        sq_vld[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rad[k]  <= {rad_i[2*W-3:0], 2'b00};
        sq_rem[k]  <= ge ? rem2 - trial : rem2;
        sq_root[k] <= {root_i[W-2:0], ge};
        sq_ctx[k]  <= ctx_i;
      end
    end
  end

  // direction divider, one quotient bit per stage; penetration and its gain ride along
  logic           dv_vld  [ND];
  logic [W-1:0]   dv_rem  [ND][3];
  logic [QB-1:0]  dv_q    [ND][3];
  logic [W-1:0]   dv_d    [ND];
  logic           dv_flag [ND];
  hhv_pkg::word_t dv_mg   [ND];
  hhv_pkg::ctx_t  dv_ctx  [ND];

  for (genvar k = 0; k < ND; k++) begin : g_div
    if (k == 0) begin : g_first
      logic [W:0] pdiff;
      assign pdiff = {1'b0, sq_root[NS-1]} - {2'b00, boundary_radius};

      always_ff @(posedge clk) begin
        if (rst) begin
          dv_vld[k] <= 1'b0;
        end else if (adv) begin
          dv_vld[k] <= sq_vld[NS-1];
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          for (int i = 0; i < 3; i++) begin
            if (hhv_pkg::mag(sq_ctx[NS-1].np[i]) >= sq_root[NS-1]) begin
              dv_rem[k][i] <= hhv_pkg::mag(sq_ctx[NS-1].np[i]) - sq_root[NS-1];
              dv_q[k][i]   <= QB'(1);
            end else begin
              dv_rem[k][i] <= hhv_pkg::mag(sq_ctx[NS-1].np[i]);
              dv_q[k][i]   <= '0;
            end
          end
          dv_d[k]    <= sq_root[NS-1];
          dv_flag[k] <= sq_root[NS-1] > {1'b0, boundary_radius};
          dv_mg[k]   <= (pdiff > (W+1)'(hhv_pkg::MAX_W)) ? hhv_pkg::MAX_W
                                                         : pdiff[W-1:0];
          dv_ctx[k]  <= sq_ctx[NS-1];
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rst) begin
          dv_vld[k] <= 1'b0;
        end else if (adv) begin
          dv_vld[k] <= dv_vld[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          for (int i = 0; i < 3; i++) begin
            if ({dv_rem[k-1][i], 1'b0} >= {1'b0, dv_d[k-1]}) begin
              dv_rem[k][i] <= W'({dv_rem[k-1][i], 1'b0} - {1'b0, dv_d[k-1]});
              dv_q[k][i]   <= {dv_q[k-1][i][QB-2:0], 1'b1};
            end else begin
              dv_rem[k][i] <= {dv_rem[k-1][i][W-2:0], 1'b0};
              dv_q[k][i]   <= {dv_q[k-1][i][QB-2:0], 1'b0};
            end
          end
          dv_d[k]    <= dv_d[k-1];
          dv_flag[k] <= dv_flag[k-1];
          dv_ctx[k]  <= dv_ctx[k-1];
          // squared penetration, then times strength
          if (k == 1) begin
            dv_mg[k] <= hhv_pkg::fx_mul(dv_mg[k-1], dv_mg[k-1]);
          end else if (k == 2) begin
            dv_mg[k] <= hhv_pkg::fx_mul(dv_mg[k-1], {1'b0, containment_strength});
          end else begin
            dv_mg[k] <= dv_mg[k-1];
          end
        end
      end
    end
  end

  // back stages: containment pull, new acceleration, final velocity
  logic           q_vld, r_vld, s_vld;
  hhv_pkg::word_t q_c [3];
  logic           q_flag;
  hhv_pkg::ctx_t  q_ctx, r_ctx, s_ctx;
  hhv_pkg::ctx_t  r_ctx_next;
  hhv_pkg::word_t s_m [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld     <= 1'b0;
      r_vld     <= 1'b0;
      s_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      q_vld     <= dv_vld[ND-1];
      r_vld     <= q_vld;
      s_vld     <= r_vld;
      out_valid <= s_vld;
    end
  end

  // pull toward the origin, against the sign of each coordinate
  always_comb begin
    r_ctx_next = q_ctx;
    for (int i = 0; i < 3; i++) begin
      if (q_flag) begin
        r_ctx_next.f[i] = q_ctx.np[i][W-1] ? hhv_pkg::sat_add(q_ctx.f[i], q_c[i])
                                           : hhv_pkg::sat_sub(q_ctx.f[i], q_c[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        q_c[i] <= hhv_pkg::fx_mul(W'(dv_q[ND-1][i]), dv_mg[ND-1]);
      end
      q_flag <= dv_flag[ND-1];
      q_ctx  <= dv_ctx[ND-1];
      r_ctx  <= r_ctx_next;
      s_ctx <= r_ctx;
      for (int i = 0; i < 3; i++) begin
        s_m[i] <= hhv_pkg::fx_mul(r_ctx.f[i], W'(r_ctx.dt));
      end
      // output beat
      new_pos_x <= s_ctx.np[0];
      new_pos_y <= s_ctx.np[1];
      new_pos_z <= s_ctx.np[2];
      new_vel_x <= hhv_pkg::sat_add(s_ctx.vh[0], hhv_pkg::fx_half(s_m[0]));
      new_vel_y <= hhv_pkg::sat_add(s_ctx.vh[1], hhv_pkg::fx_half(s_m[1]));
      new_vel_z <= hhv_pkg::sat_add(s_ctx.vh[2], hhv_pkg::fx_half(s_m[2]));
      new_acc_x <= s_ctx.f[0];
      new_acc_y <= s_ctx.f[1];
      new_acc_z <= s_ctx.f[2];
    end
  end

  // direction ratio never exceeds one when containment acts
  assert property (@(posedge clk) disable iff (rst)
    dv_vld[ND-1] && dv_flag[ND-1] |->
      dv_q[ND-1][0] <= (QB'(1) << hhv_pkg::FRAC_BITS) &&
      dv_q[ND-1][1] <= (QB'(1) << hhv_pkg::FRAC_BITS) &&
      dv_q[ND-1][2] <= (QB'(1) << hhv_pkg::FRAC_BITS))
    else $error("direction ratio above one");

  // a stall freezes the valid bits inside the pipeline
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(sq_vld[NS-1]) && $stable(dv_vld[ND-1]) && $stable(s_vld))
    else $error("pipeline moved during stall");

  // reset empties the output register
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
